/* src/lpr_pkg.sv */
`default_nettype none

package lpr_pkg;

    localparam int ELAPSED_W = 18;
    localparam int LEVEL_W   = 9;

    localparam logic [ELAPSED_W-1:0] TICK_MS       = ELAPSED_W'(10);
    localparam logic [15:0]          ENDLESS_COUNT = 16'hFFFF;
    localparam logic [15:0]          COUNT_MAX     = 16'hFFFF;

    localparam logic signed [LEVEL_W-1:0] LEVEL_FULL = 9'sd100;
    localparam logic signed [LEVEL_W-1:0] LEVEL_HALF = 9'sd50;
    localparam logic signed [LEVEL_W-1:0] LEVEL_OFF  = 9'sd0;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_PULSE  = 2'd1,
        MODE_RAMP   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_START  = 2'd3
    } t_cmd;

    localparam logic [2:0] CFG_PATTERN_SELECT = 3'd0;
    localparam logic [2:0] CFG_ON_TIME        = 3'd1;
    localparam logic [2:0] CFG_OFF_TIME       = 3'd2;
    localparam logic [2:0] CFG_PULSE_REPEATS  = 3'd3;
    localparam logic [2:0] CFG_RAMP_LOW       = 3'd4;
    localparam logic [2:0] CFG_RAMP_HIGH      = 3'd5;
    localparam logic [2:0] CFG_STEP_UP        = 3'd6;
    localparam logic [2:0] CFG_STEP_DOWN      = 3'd7;

    typedef struct packed {
        logic              pattern_select;
        logic [15:0]       on_time_ms;
        logic [15:0]       off_time_ms;
        logic [15:0]       pulse_repeats;
        logic signed [7:0] ramp_low;
        logic signed [7:0] ramp_high;
        logic [6:0]        step_up;
        logic [6:0]        step_down;
    } t_cfg;

    // clamp a raw signed byte to [-100, 100], widened to level width
    function automatic logic signed [LEVEL_W-1:0] sat100(input logic signed [7:0] v);
        logic signed [LEVEL_W-1:0] w;
        w = LEVEL_W'(v);
        if (w > LEVEL_FULL) begin
            return LEVEL_FULL;
        end else if (w < -LEVEL_FULL) begin
            return -LEVEL_FULL;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/lpr_cfg_regs.sv */
`default_nettype none

module lpr_cfg_regs
    import lpr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_select <= 1'b0;
            r_cfg.on_time_ms     <= '0;
            r_cfg.off_time_ms    <= '0;
            r_cfg.pulse_repeats  <= '0;
            r_cfg.ramp_low       <= 8'sd0;
            r_cfg.ramp_high      <= 8'sd100;
            r_cfg.step_up        <= 7'd1;
            r_cfg.step_down      <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_SELECT: r_cfg.pattern_select <= i_cfg_data[0];
                CFG_ON_TIME:        r_cfg.on_time_ms     <= i_cfg_data;
                CFG_OFF_TIME:       r_cfg.off_time_ms    <= i_cfg_data;
                CFG_PULSE_REPEATS:  r_cfg.pulse_repeats  <= i_cfg_data;
                CFG_RAMP_LOW:       r_cfg.ramp_low       <= i_cfg_data[7:0];
                CFG_RAMP_HIGH:      r_cfg.ramp_high      <= i_cfg_data[7:0];
                CFG_STEP_UP:        r_cfg.step_up        <= i_cfg_data[6:0];
                CFG_STEP_DOWN:      r_cfg.step_down      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* src/lpr_core.sv */
`default_nettype none

module lpr_core
    import lpr_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_fire,
    input  wire logic [1:0]                i_command,
    input  wire logic signed [7:0]         i_level,
    input  wire t_cfg                      i_cfg,
    output logic signed [LEVEL_W-1:0]      o_level_next,
    output t_mode                          o_mode_next
);

    t_mode                      r_mode,    n_mode;
    logic                       r_pend,    n_pend;
    logic [ELAPSED_W-1:0]       r_elapsed, n_elapsed;
    logic [15:0]                r_count,   n_count;
    logic signed [LEVEL_W-1:0]  r_level,   n_level;
    logic                       r_falling, n_falling;

    logic [16:0]                period;
    logic [ELAPSED_W-1:0]       e_base;
    logic [15:0]                count_inc;
    logic signed [LEVEL_W-1:0]  ramp_lo;
    logic signed [LEVEL_W-1:0]  ramp_hi;
    logic signed [LEVEL_W-1:0]  up_sum;
    logic signed [LEVEL_W-1:0]  dn_sum;

    assign period    = {1'b0, i_cfg.on_time_ms} + {1'b0, i_cfg.off_time_ms};
    // a fresh entry restarts the pulse timer
    assign e_base    = r_pend ? '0 : r_elapsed;
    assign count_inc = (i_cfg.pulse_repeats != ENDLESS_COUNT && r_count != COUNT_MAX)
                       ? r_count + 16'd1 : r_count;
    assign ramp_lo   = sat100(i_cfg.ramp_low);
    assign ramp_hi   = sat100(i_cfg.ramp_high);
    // level stays in [-100, 100], so 9 bits hold +/-227
    assign up_sum    = r_level + $signed({2'b00, i_cfg.step_up});
    assign dn_sum    = r_level - $signed({2'b00, i_cfg.step_down});

    always_comb begin
        n_mode    = r_mode;
        n_pend    = r_pend;
        n_elapsed = r_elapsed;
        n_count   = r_count;
        n_level   = r_level;
        n_falling = r_falling;
        unique case (t_cmd'(i_command))
            CMD_TICK: begin
                if (r_mode == MODE_PULSE) begin
                    n_level = (e_base < {2'b00, i_cfg.on_time_ms}) ? LEVEL_FULL : LEVEL_OFF;
                    if (e_base >= {1'b0, period}) begin
                        n_count = count_inc;
                        if (count_inc >= i_cfg.pulse_repeats) begin
                            n_mode    = MODE_MANUAL;
                            n_level   = LEVEL_OFF;
                            n_elapsed = e_base;
                        end else begin
                            n_elapsed = '0;
                        end
                    end else begin
                        n_elapsed = e_base + TICK_MS;
                    end
                end else if (r_mode == MODE_RAMP) begin
                    if (r_pend) begin
                        n_level   = ramp_lo;
                        n_falling = 1'b0;
                    end else if (!r_falling) begin
                        n_level = up_sum;
                        if (up_sum >= ramp_hi) begin
                            n_level   = ramp_hi;
                            n_falling = 1'b1;
                        end
                    end else begin
                        n_level = dn_sum;
                        if (dn_sum <= ramp_lo) begin
                            n_level   = ramp_lo;
                            n_falling = 1'b0;
                        end
                    end
                end
                n_pend = 1'b0;
            end
            CMD_SET: begin
                n_level = sat100(i_level);
                n_mode  = MODE_MANUAL;
                n_pend  = 1'b0;
            end
            CMD_TOGGLE: begin
                n_level = (r_level > LEVEL_HALF) ? LEVEL_OFF : LEVEL_FULL;
                n_mode  = MODE_MANUAL;
                n_pend  = 1'b0;
            end
            CMD_START: begin
                if (!i_cfg.pattern_select) begin
                    n_elapsed = '0;
                    n_count   = '0;
                    n_mode    = MODE_PULSE;
                end else begin
                    n_mode = MODE_RAMP;
                end
                n_pend = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_MANUAL;
            r_pend    <= 1'b0;
            r_elapsed <= '0;
            r_count   <= '0;
            r_level   <= LEVEL_OFF;
            r_falling <= 1'b0;
        end else if (i_fire) begin
            r_mode    <= n_mode;
            r_pend    <= n_pend;
            r_elapsed <= n_elapsed;
            r_count   <= n_count;
            r_level   <= n_level;
            r_falling <= n_falling;
        end
    end

    assign o_level_next = n_level;
    assign o_mode_next  = n_mode;

endmodule

`default_nettype wire

/* src/led_pulse_ramp_driver.sv */
// A word accepted passes the input register, then the result register, before
// its result word is on the outputs. Throughput: one word per cycle while the
// result side does not stall; the state update is one add/compare pass.
// Reset (synchronous, active low): manual mode at level 0, both pipeline
// stages empty, configuration back to its default values.
`default_nettype none

module led_pulse_ramp_driver
    import lpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic signed [7:0] i_level,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic signed [7:0]      o_drive_percent,
    output logic                   o_bridge_a,
    output logic                   o_bridge_b,
    output logic [1:0]             o_active_mode,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);

    t_cfg                       cfg;
    logic                       out_free;
    logic                       fire;
    logic signed [LEVEL_W-1:0]  level_next;
    t_mode                      mode_next;

    logic                       r_in_valid;
    logic [1:0]                 r_cmd;
    logic signed [7:0]          r_level;
    logic                       r_out_valid;
    logic signed [7:0]          r_drive;
    logic                       r_bridge_a;
    logic                       r_bridge_b;
    t_mode                      r_mode_out;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    lpr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_command    (r_cmd),
        .i_level      (r_level),
        .i_cfg        (cfg),
        .o_level_next (level_next),
        .o_mode_next  (mode_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd   <= i_command;
            r_level <= i_level;
        end
        if (fire) begin
            r_drive    <= level_next[7:0];
            r_bridge_a <= (level_next <= LEVEL_OFF);
            r_bridge_b <= (level_next >= LEVEL_OFF);
            r_mode_out <= mode_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_percent = r_drive;
    assign o_bridge_a      = r_bridge_a;
    assign o_bridge_b      = r_bridge_b;
    assign o_active_mode   = r_mode_out;

endmodule

`default_nettype wire

/* src/lpr_checker.sv */
`default_nettype none

module lpr_checker
    import lpr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              o_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic signed [7:0] o_drive_percent,
    input  wire logic              o_bridge_a,
    input  wire logic              o_bridge_b,
    input  wire logic [1:0]        o_active_mode
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_drive_percent)
            && $stable(o_active_mode))
        else $error("stalled result word changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_percent <= 8'sd100) && (o_drive_percent >= -8'sd100)
            && (o_active_mode != 2'd3))
        else $error("drive level or mode out of range");

    // direction bits follow the sign of the level, both set at zero
    a_bridge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bridge_a == (o_drive_percent <= 8'sd0))
            && (o_bridge_b == (o_drive_percent >= 8'sd0)))
        else $error("bridge bits disagree with level");

endmodule

bind led_pulse_ramp_driver lpr_checker u_lpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_drive_percent (o_drive_percent),
    .o_bridge_a      (o_bridge_a),
    .o_bridge_b      (o_bridge_b),
    .o_active_mode   (o_active_mode)
);

`default_nettype wire

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int N_DIR       = 33;
    localparam int RAND_WORDS  = 1150;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic signed [7:0] drive;
        logic              bridge_a;
        logic              bridge_b;
        logic [1:0]        mode;
    } t_result;

    localparam t_result NO_WANT = '0;

    typedef struct {
        logic              is_cfg;
        logic [2:0]        reg_idx;
        logic [15:0]       reg_val;
        t_cmd              cmd;
        logic signed [7:0] lvl;
        logic              known;
        t_result           want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [1:0]             i_command;
    logic signed [7:0]      i_level;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [7:0]      o_drive_percent;
    logic                   o_bridge_a;
    logic                   o_bridge_b;
    logic [1:0]             o_active_mode;
    logic                   i_cfg_we;
    logic [2:0]             i_cfg_index;
    logic [15:0]            i_cfg_data;

    // typed expectation travels with the word it belongs to
    logic                   row_known;
    t_result                row_want;

    // shadow copy of the controller
    t_cfg                        shadow_cfg;
    t_mode                       pat_mode;
    logic                        entry_armed;
    logic [ELAPSED_W-1:0]        elapsed_ms;
    logic [15:0]                 pulses_done;
    logic signed [LEVEL_W-1:0]   duty;
    logic                        ramp_down;

    t_result pending_drive[$];
    t_result want_w;
    t_result calc_w;
    int      n_fail = 0;
    int      quiet_cycles = 0;
    int      burst_left = 0;
    logic    gaps_on = 1'b1;
    logic    hold_off_req = 1'b0;

    t_row dir_rows [0:N_DIR-1] = '{
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd85,  1, '{8'sd0,   1, 1, MODE_MANUAL}},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_SET,    8'sd127, 1, '{8'sd100, 0, 1, MODE_MANUAL}},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_SET,    8'sh80,  1, '{-8'sd100, 1, 0, MODE_MANUAL}},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TOGGLE, 8'sd0,   1, '{8'sd100, 0, 1, MODE_MANUAL}},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TOGGLE, 8'sh7F,  1, '{8'sd0,   1, 1, MODE_MANUAL}},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_SET,    8'sd50,  1, '{8'sd50,  0, 1, MODE_MANUAL}},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TOGGLE, 8'sd0,   1, '{8'sd100, 0, 1, MODE_MANUAL}},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_SET,    8'sd51,  1, '{8'sd51,  0, 1, MODE_MANUAL}},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TOGGLE, 8'sh80,  1, '{8'sd0,   1, 1, MODE_MANUAL}},
        // zero repeats, zero times: one pulse then back to manual
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_START,  8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        '{1, CFG_ON_TIME,        16'd20, CMD_TICK,  8'sd0,   0, NO_WANT},
        '{1, CFG_OFF_TIME,       16'd10, CMD_TICK,  8'sd0,   0, NO_WANT},
        '{1, CFG_PULSE_REPEATS,  16'd1,  CMD_TICK,  8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_START,  8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        // restart while the pulse is already armed, then leave by set
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_START,  8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_START,  8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_SET,    8'sd77,  0, NO_WANT},
        '{1, CFG_PATTERN_SELECT, 16'd1,  CMD_TICK,  8'sd0,   0, NO_WANT},
        '{1, CFG_RAMP_LOW,       16'h0080, CMD_TICK, 8'sd0,  0, NO_WANT},
        '{1, CFG_RAMP_HIGH,      16'h007F, CMD_TICK, 8'sd0,  0, NO_WANT},
        '{1, CFG_STEP_UP,        16'd100, CMD_TICK, 8'sd0,   0, NO_WANT},
        '{1, CFG_STEP_DOWN,      16'd127, CMD_TICK, 8'sd0,   0, NO_WANT},
        // ramp with out-of-range bounds, clamped at both ends
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_START,  8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TICK,   8'sd0,   0, NO_WANT},
        '{0, CFG_PATTERN_SELECT, 16'd0, CMD_TOGGLE, 8'sd0,   0, NO_WANT}
    };

    led_pulse_ramp_driver u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_level         (i_level),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_drive_percent (o_drive_percent),
        .o_bridge_a      (o_bridge_a),
        .o_bridge_b      (o_bridge_b),
        .o_active_mode   (o_active_mode),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic signed [LEVEL_W-1:0] pct_clamp(input logic signed [7:0] raw);
        if (raw > 8'sd100) begin
            return LEVEL_FULL;
        end
        if (raw < -8'sd100) begin
            return -LEVEL_FULL;
        end
        return LEVEL_W'(raw);
    endfunction

    // advance the shadow controller by one command word, return the drive it shows
    function automatic t_result led_drive_after(input t_cmd cmd, input logic signed [7:0] lvl);
        logic [16:0]               period;
        logic signed [LEVEL_W-1:0] lo;
        logic signed [LEVEL_W-1:0] hi;
        t_result                   res;
        case (cmd)
            CMD_TICK: begin
                if (pat_mode == MODE_PULSE) begin
                    period = {1'b0, shadow_cfg.on_time_ms} + {1'b0, shadow_cfg.off_time_ms};
                    if (entry_armed) begin
                        elapsed_ms = '0;
                    end
                    duty = (elapsed_ms < ELAPSED_W'(shadow_cfg.on_time_ms)) ? LEVEL_FULL
                                                                             : LEVEL_OFF;
                    if (elapsed_ms >= ELAPSED_W'(period)) begin
                        if (shadow_cfg.pulse_repeats != ENDLESS_COUNT && pulses_done != COUNT_MAX) begin
                            pulses_done = pulses_done + 16'd1;
                        end
                        if (pulses_done >= shadow_cfg.pulse_repeats) begin
                            duty = LEVEL_OFF;
                            pat_mode = MODE_MANUAL;
                        end else begin
                            elapsed_ms = '0;
                        end
                    end else begin
                        elapsed_ms = elapsed_ms + TICK_MS;
                    end
                end else if (pat_mode == MODE_RAMP) begin
                    lo = pct_clamp(shadow_cfg.ramp_low);
                    hi = pct_clamp(shadow_cfg.ramp_high);
                    if (entry_armed) begin
                        duty = lo;
                        ramp_down = 1'b0;
                    end else if (!ramp_down) begin
                        duty = duty + $signed({2'b00, shadow_cfg.step_up});
                        if (duty >= hi) begin
                            duty = hi;
                            ramp_down = 1'b1;
                        end
                    end else begin
                        duty = duty - $signed({2'b00, shadow_cfg.step_down});
                        if (duty <= lo) begin
                            duty = lo;
                            ramp_down = 1'b0;
                        end
                    end
                end
                entry_armed = 1'b0;
            end
            CMD_SET: begin
                duty = pct_clamp(lvl);
                pat_mode = MODE_MANUAL;
                entry_armed = 1'b0;
            end
            CMD_TOGGLE: begin
                duty = (duty > LEVEL_HALF) ? LEVEL_OFF : LEVEL_FULL;
                pat_mode = MODE_MANUAL;
                entry_armed = 1'b0;
            end
            default: begin
                if (!shadow_cfg.pattern_select) begin
                    elapsed_ms = '0;
                    pulses_done = '0;
                    pat_mode = MODE_PULSE;
                end else begin
                    pat_mode = MODE_RAMP;
                end
                entry_armed = 1'b1;
            end
        endcase
        res.drive    = duty[7:0];
        res.bridge_a = (duty <= 0);
        res.bridge_b = (duty >= 0);
        res.mode     = pat_mode;
        return res;
    endfunction

    // caller must hold the block idle; unused upper data bits may get random junk
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
        logic [15:0] keep;
        logic [15:0] data;
        case (idx)
            CFG_PATTERN_SELECT:          keep = 16'h0001;
            CFG_RAMP_LOW, CFG_RAMP_HIGH: keep = 16'h00FF;
            CFG_STEP_UP, CFG_STEP_DOWN:  keep = 16'h007F;
            default:                     keep = 16'hFFFF;
        endcase
        data = value & keep;
        if ($urandom_range(0, 1) == 1) begin
            data = data | (16'($urandom) & ~keep);
        end
        case (idx)
            CFG_PATTERN_SELECT: shadow_cfg.pattern_select = data[0];
            CFG_ON_TIME:        shadow_cfg.on_time_ms     = data;
            CFG_OFF_TIME:       shadow_cfg.off_time_ms    = data;
            CFG_PULSE_REPEATS:  shadow_cfg.pulse_repeats  = data;
            CFG_RAMP_LOW:       shadow_cfg.ramp_low       = data[7:0];
            CFG_RAMP_HIGH:      shadow_cfg.ramp_high      = data[7:0];
            CFG_STEP_UP:        shadow_cfg.step_up        = data[6:0];
            default:            shadow_cfg.step_down      = data[6:0];
        endcase
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic send_word(input t_cmd cmd, input logic signed [7:0] lvl,
                             input logic known, input t_result want);
        int gap;
        i_cfg_we <= 1'b0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!gaps_on) begin
                gap = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(5, 30);
            end else begin
                gap = $urandom_range(0, 3);
            end
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_level    <= lvl;
        row_known  <= known;
        row_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop offering and wait until every word in flight has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        i_cfg_we   <= 1'b0;
        do @(negedge i_clk); while (pending_drive.size() != 0);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_drive.size() == 0) begin
                    $display("%0t ns: result word with nothing expected: drive %0d mode %0d",
                             $time, o_drive_percent, o_active_mode);
                    n_fail++;
                end else begin
                    want_w = pending_drive.pop_front();
                    if (o_drive_percent !== want_w.drive) begin
                        $display("%0t ns: drive_percent expected %0d, got %0d",
                                 $time, want_w.drive, o_drive_percent);
                        n_fail++;
                    end
                    if (o_bridge_a !== want_w.bridge_a) begin
                        $display("%0t ns: bridge_a expected %0b, got %0b",
                                 $time, want_w.bridge_a, o_bridge_a);
                        n_fail++;
                    end
                    if (o_bridge_b !== want_w.bridge_b) begin
                        $display("%0t ns: bridge_b expected %0b, got %0b",
                                 $time, want_w.bridge_b, o_bridge_b);
                        n_fail++;
                    end
                    if (o_active_mode !== want_w.mode) begin
                        $display("%0t ns: active_mode expected %0d, got %0d",
                                 $time, want_w.mode, o_active_mode);
                        n_fail++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                calc_w = led_drive_after(t_cmd'(i_command), i_level);
                pending_drive.push_back(row_known ? row_want : calc_w);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side: stall segments of varying character, one long hold-off on request
    initial begin
        int seg_len;
        int seg_kind;
        int beat;
        i_out_ready <= 1'b0;
        beat = 0;
        forever begin
            seg_len  = $urandom_range(10, 150);
            seg_kind = $urandom_range(0, 3);
            repeat (seg_len) begin
                @(posedge i_clk);
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    i_out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                beat++;
                case (seg_kind)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= ($urandom_range(0, 1) == 1);
                    2:       i_out_ready <= (beat % 4 != 0);
                    default: i_out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial begin
        logic [15:0] cfg_vals [8];
        int          rand_words;
        int          target;
        int          run_len;
        int          phase;
        logic signed [7:0] lo_pick;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= CMD_TICK;
        i_level     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_PATTERN_SELECT;
        i_cfg_data  <= '0;
        row_known   <= 1'b0;
        row_want    <= NO_WANT;

        shadow_cfg = '{pattern_select: 1'b0, on_time_ms: 16'd0, off_time_ms: 16'd0,
                       pulse_repeats: 16'd0, ramp_low: 8'sd0, ramp_high: 8'sd100,
                       step_up: 7'd1, step_down: 7'd1};
        pat_mode    = MODE_MANUAL;
        entry_armed = 1'b0;
        elapsed_ms  = '0;
        pulses_done = '0;
        duty        = LEVEL_OFF;
        ramp_down   = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].is_cfg) begin
                wait_drained();
                cfg_write(dir_rows[r].reg_idx, dir_rows[r].reg_val);
            end else begin
                send_word(dir_rows[r].cmd, dir_rows[r].lvl, dir_rows[r].known,
                          dir_rows[r].want);
            end
        end

        rand_words = 0;
        phase = 0;
        while (rand_words < RAND_WORDS) begin
            wait_drained();
            if (phase == 0) begin
                cfg_vals[CFG_PATTERN_SELECT] = 16'd0;
                cfg_vals[CFG_ON_TIME]        = 16'd0;
                cfg_vals[CFG_OFF_TIME]       = 16'd0;
                cfg_vals[CFG_PULSE_REPEATS]  = 16'd0;
                cfg_vals[CFG_RAMP_LOW]       = 16'h0080;
                cfg_vals[CFG_RAMP_HIGH]      = 16'h0080;
                cfg_vals[CFG_STEP_UP]        = 16'd0;
                cfg_vals[CFG_STEP_DOWN]      = 16'd0;
            end else if (phase == 1) begin
                cfg_vals[CFG_PATTERN_SELECT] = 16'd1;
                cfg_vals[CFG_ON_TIME]        = 16'hFFFF;
                cfg_vals[CFG_OFF_TIME]       = 16'hFFFF;
                cfg_vals[CFG_PULSE_REPEATS]  = 16'hFFFF;
                cfg_vals[CFG_RAMP_LOW]       = 16'h007F;
                cfg_vals[CFG_RAMP_HIGH]      = 16'h007F;
                cfg_vals[CFG_STEP_UP]        = 16'h007F;
                cfg_vals[CFG_STEP_DOWN]      = 16'h007F;
            end else begin
                cfg_vals[CFG_PATTERN_SELECT] = 16'($urandom_range(0, 1));
                cfg_vals[CFG_ON_TIME]  = ($urandom_range(0, 7) == 0) ?
                                         16'($urandom_range(0, 2000)) : 16'($urandom_range(0, 60));
                cfg_vals[CFG_OFF_TIME] = ($urandom_range(0, 7) == 0) ?
                                         16'($urandom_range(0, 2000)) : 16'($urandom_range(0, 60));
                case ($urandom_range(0, 9))
                    0:       cfg_vals[CFG_PULSE_REPEATS] = 16'd0;
                    1:       cfg_vals[CFG_PULSE_REPEATS] = ENDLESS_COUNT;
                    2:       cfg_vals[CFG_PULSE_REPEATS] = 16'($urandom);
                    default: cfg_vals[CFG_PULSE_REPEATS] = 16'($urandom_range(1, 4));
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    // any byte: out-of-range and crossed bounds
                    cfg_vals[CFG_RAMP_LOW]  = 16'($urandom_range(0, 255));
                    cfg_vals[CFG_RAMP_HIGH] = 16'($urandom_range(0, 255));
                end else begin
                    lo_pick = 8'($signed($urandom_range(0, 150)) - 100);
                    cfg_vals[CFG_RAMP_LOW]  = {8'h00, lo_pick};
                    cfg_vals[CFG_RAMP_HIGH] = {8'h00, 8'(lo_pick + 8'($urandom_range(0, 100 - lo_pick)))};
                end
                cfg_vals[CFG_STEP_UP]   = ($urandom_range(0, 4) == 0) ?
                                          16'($urandom_range(0, 127)) : 16'($urandom_range(1, 25));
                cfg_vals[CFG_STEP_DOWN] = ($urandom_range(0, 4) == 0) ?
                                          16'($urandom_range(0, 127)) : 16'($urandom_range(1, 25));
            end
            for (int r = 0; r < 8; r++) begin
                cfg_write(3'(r), cfg_vals[r]);
            end

            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase == 3) begin
                hold_off_req = 1'b1;
            end
            target = rand_words + $urandom_range(60, 120);
            while (rand_words < target) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_word(t_cmd'($urandom_range(0, 3)), 8'($urandom), 1'b0, NO_WANT);
                    rand_words++;
                end else begin
                    // start followed by a run of ticks, now and then broken up
                    send_word(CMD_START, 8'($urandom), 1'b0, NO_WANT);
                    rand_words++;
                    run_len = $urandom_range(1, 40);
                    repeat (run_len) begin
                        send_word(($urandom_range(0, 19) == 0) ? t_cmd'($urandom_range(1, 3))
                                                               : CMD_TICK,
                                  8'($urandom), 1'b0, NO_WANT);
                        rand_words++;
                    end
                end
            end
            phase++;
        end

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
